/* rtl/frt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared widths, status codes and payload types.
// ----------------------------------------------------------------------------
package frt_pkg;

   localparam int PoolSlots = 16;
   localparam int MaxParts  = 32;
   localparam int SlotW     = $clog2(PoolSlots);
   localparam int MsW       = 48;

   localparam logic [2:0] ST_STORED    = 3'd0;
   localparam logic [2:0] ST_COMPLETE  = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_BAD       = 3'd4;
   localparam logic [2:0] ST_TICK      = 3'd5;

   localparam logic [1:0] REG_MAX_AGE  = 2'd0;
   localparam logic [1:0] REG_INTERVAL = 2'd1;
   localparam logic [1:0] REG_ENABLE   = 2'd2;

   typedef struct packed {
      logic        func;
      logic [63:0] sender_hi;
      logic [63:0] sender_lo;
      logic [31:0] sequence_req;
      logic [4:0]  part_index;
      logic [5:0]  part_count;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic [4:0] pruned_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [15:0] data;
   } csr_type;

   // One table entry as held in memory.
   typedef struct packed {
      logic [63:0]    sender_hi;
      logic [63:0]    sender_lo;
      logic [31:0]    sequence_num;
      logic [5:0]     parts_total;
      logic [31:0]    received_map;
      logic [5:0]     received_count;
      logic [MsW-1:0] birth_ms;
   } entry_type;

endpackage

/* rtl/frt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface frt_req_if;
   import frt_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface frt_rsp_if;
   import frt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface frt_csr_if;
   import frt_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/fragment_reassembly_tracker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Slot table of partly received messages with periodic age pruning.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (func 0 is a fragment, func 1 a one
// millisecond tick); each request yields exactly one response transaction on
// rsp. Registers are written on csr (index 0 max age in seconds, 1 prune
// interval in ms, 2 prune enable) while the block is idle; csr is always ready.
// The slot table lives in a synchronous memory with one read and one write
// port; valid bits are flip-flops. A fragment reads every slot in turn, one
// per cycle, re-reads the matching slot and writes back at most one entry
// before its response is offered. A fragment with a bad count or index is
// answered in the next cycle. A tick without a scan passes through S_TICK
// before its response is offered. A pruning scan takes each slot through
// S_SCAN_RD and S_SCAN_NEXT, and a valid slot also through S_SCAN_DIV and
// S_SCAN_WAIT for the age check. A new request is taken from the cycle after
// the response has gone.
// Reset clears the valid bits, the millisecond clock and the interval
// counter; the memory needs no clearing pass. A response waits in its output
// register while the receiver stalls; no new request is taken until it goes.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_top (
   input logic clock,
   input logic reset,
   frt_req_if.sink   req,
   frt_rsp_if.source rsp,
   frt_csr_if.sink   csr
);
   import frt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_SRCH_LAST, S_REREAD, S_UPDATE, S_WRITE,
      S_TICK, S_SCAN_RD, S_SCAN_DIV, S_SCAN_WAIT, S_SCAN_NEXT, S_OUT
   } state_type;

   entry_type mem [PoolSlots];
   entry_type rd_data_ff;

   state_type          state_ff;
   req_type            req_ff;
   rsp_type            rsp_ff;
   logic [PoolSlots-1:0] valid_ff;
   logic [SlotW:0]     idx_ff;
   logic [SlotW-1:0]   rd_slot_ff;
   logic               found_ff, free_ok_ff;
   logic [SlotW-1:0]   found_slot_ff, free_slot_ff;
   logic [MsW-1:0]     now_ff;
   logic [15:0]        interval_ff;
   logic [15:0]        max_age_ff, prune_int_ff;
   logic               enable_ff;
   logic [4:0]         pruned_ff;
   logic               wr_en;
   logic [SlotW-1:0]   wr_addr, rd_addr;
   entry_type          wr_data;
   logic               div_start, div_done;
   logic               div_over;
   logic [SlotW-1:0]   cur_slot;
   logic               match;
   logic [31:0]        bit_mask;
   logic [5:0]         new_count;
   logic [15:0]        interval_next;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = rsp_ff;

   assign cur_slot = idx_ff[SlotW-1:0];
   assign rd_addr  = cur_slot;
   assign match    = valid_ff[rd_slot_ff] &&
                     rd_data_ff.sender_hi == req_ff.sender_hi &&
                     rd_data_ff.sender_lo == req_ff.sender_lo &&
                     rd_data_ff.sequence_num == req_ff.sequence_req;
   assign bit_mask  = 32'd1 << req_ff.part_index;
   assign new_count = rd_data_ff.received_count + 6'd1;
   assign interval_next = interval_ff + 16'd1;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   frt_age_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .age_ms    (MsW'(now_ff - rd_data_ff.birth_ms)),
      .max_age_s (max_age_ff),
      .done      (div_done),
      .over      (div_over)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = found_slot_ff;
      wr_data = rd_data_ff;
      if (state_ff == S_WRITE) begin
         wr_en = 1'b1;
         if (found_ff) begin
            wr_data.received_map   = rd_data_ff.received_map | bit_mask;
            wr_data.received_count = new_count;
         end else begin
            wr_addr                = free_slot_ff;
            wr_data.sender_hi      = req_ff.sender_hi;
            wr_data.sender_lo      = req_ff.sender_lo;
            wr_data.sequence_num   = req_ff.sequence_req;
            wr_data.parts_total    = req_ff.part_count;
            wr_data.received_map   = bit_mask;
            wr_data.received_count = 6'd1;
            wr_data.birth_ms       = now_ff;
         end
      end
      div_start = (state_ff == S_SCAN_DIV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         now_ff       <= '0;
         interval_ff  <= '0;
         max_age_ff   <= 16'd20;
         prune_int_ff <= 16'd1000;
         enable_ff    <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (csr.valid) begin
            case (csr.data.index)
               REG_MAX_AGE:  max_age_ff   <= csr.data.data;
               REG_INTERVAL: prune_int_ff <= csr.data.data;
               REG_ENABLE:   enable_ff    <= csr.data.data[0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  req_ff   <= req.data;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  free_ok_ff <= 1'b0;
                  pruned_ff <= '0;
                  if (req.data.func) begin
                     state_ff <= S_TICK;
                  end else if (req.data.part_count == 6'd0 ||
                               req.data.part_count > 6'(MaxParts) ||
                               {1'b0, req.data.part_index} >= req.data.part_count) begin
                     rsp_ff   <= '{status: ST_BAD, slot: 4'd0, pruned_count: 5'd0};
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_SRCH;
                  end
               end
            end
            // Address idx_ff is issued; the data of rd_slot_ff is checked.
            S_SRCH, S_SRCH_LAST: begin
               if (state_ff == S_SRCH_LAST) begin
                  // Point the read address at the matching slot for the re-read.
                  if (!found_ff && match) begin
                     found_ff <= 1'b1; found_slot_ff <= rd_slot_ff;
                     idx_ff   <= {1'b0, rd_slot_ff};
                  end else if (found_ff) begin
                     idx_ff   <= {1'b0, found_slot_ff};
                  end
                  state_ff <= S_REREAD;
               end else begin
                  if (idx_ff != '0) begin
                     if (!found_ff && match) begin
                        found_ff <= 1'b1; found_slot_ff <= rd_slot_ff;
                     end
                  end
                  if (!valid_ff[cur_slot] && !free_ok_ff) begin
                     free_ok_ff <= 1'b1; free_slot_ff <= cur_slot;
                  end
                  rd_slot_ff <= cur_slot;
                  idx_ff     <= idx_ff + 1'b1;
                  if (idx_ff == (SlotW+1)'(PoolSlots - 1)) state_ff <= S_SRCH_LAST;
               end
            end
            // The matching slot is addressed; its data arrives next cycle.
            S_REREAD: state_ff <= S_UPDATE;
            S_UPDATE: begin
               if (found_ff) begin
                  if (rd_data_ff.parts_total != req_ff.part_count) begin
                     rsp_ff   <= '{status: ST_BAD, slot: 4'(found_slot_ff),
                                   pruned_count: 5'd0};
                     state_ff <= S_OUT;
                  end else if ((rd_data_ff.received_map & bit_mask) != '0) begin
                     rsp_ff   <= '{status: ST_DUPLICATE, slot: 4'(found_slot_ff),
                                   pruned_count: 5'd0};
                     state_ff <= S_OUT;
                  end else if (new_count == req_ff.part_count) begin
                     valid_ff[found_slot_ff] <= 1'b0;
                     rsp_ff   <= '{status: ST_COMPLETE, slot: 4'(found_slot_ff),
                                   pruned_count: 5'd0};
                     state_ff <= S_OUT;
                  end else begin
                     rsp_ff   <= '{status: ST_STORED, slot: 4'(found_slot_ff),
                                   pruned_count: 5'd0};
                     state_ff <= S_WRITE;
                  end
               end else if (!free_ok_ff) begin
                  rsp_ff   <= '{status: ST_FULL, slot: 4'd0, pruned_count: 5'd0};
                  state_ff <= S_OUT;
               end else if (req_ff.part_count == 6'd1) begin
                  rsp_ff   <= '{status: ST_COMPLETE, slot: 4'(free_slot_ff),
                                pruned_count: 5'd0};
                  state_ff <= S_OUT;
               end else begin
                  valid_ff[free_slot_ff] <= 1'b1;
                  rsp_ff   <= '{status: ST_STORED, slot: 4'(free_slot_ff),
                                pruned_count: 5'd0};
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: state_ff <= S_OUT;
            S_TICK: begin
               now_ff <= now_ff + 1'b1;
               idx_ff <= '0;
               if (enable_ff) begin
                  if (interval_next >= prune_int_ff) begin
                     interval_ff <= '0;
                     state_ff    <= S_SCAN_RD;
                  end else begin
                     interval_ff <= interval_next;
                     rsp_ff   <= '{status: ST_TICK, slot: 4'd0, pruned_count: 5'd0};
                     state_ff <= S_OUT;
                  end
               end else begin
                  interval_ff <= '0;
                  rsp_ff   <= '{status: ST_TICK, slot: 4'd0, pruned_count: 5'd0};
                  state_ff <= S_OUT;
               end
            end
            // Address cur_slot is presented this cycle.
            S_SCAN_RD: begin
               rd_slot_ff <= cur_slot;
               if (valid_ff[cur_slot]) state_ff <= S_SCAN_DIV;
               else state_ff <= S_SCAN_NEXT;
            end
            S_SCAN_DIV: state_ff <= S_SCAN_WAIT;
            S_SCAN_WAIT: begin
               if (div_done) begin
                  if (div_over) begin
                     valid_ff[rd_slot_ff] <= 1'b0;
                     if (pruned_ff != 5'd31) pruned_ff <= pruned_ff + 5'd1;
                  end
                  state_ff <= S_SCAN_NEXT;
               end
            end
            S_SCAN_NEXT: begin
               if (idx_ff == (SlotW+1)'(PoolSlots - 1)) begin
                  rsp_ff   <= '{status: ST_TICK, slot: 4'd0, pruned_count: pruned_ff};
                  state_ff <= S_OUT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_OUT: if (rsp.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* rtl/frt_age_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker age check
// Tells whether a 48-bit age in milliseconds exceeds a limit in whole seconds.
// ----------------------------------------------------------------------------
module frt_age_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [frt_pkg::MsW-1:0] age_ms,
   input  logic [15:0]             max_age_s,
   output logic                    done,
   output logic                    over
);
   import frt_pkg::*;

   logic [16:0] limit_s;
   logic [26:0] limit_ms;
   logic        over_ff, over_in;
   logic        done_ff, done_in;

   // The whole-second age exceeds the limit exactly when the age in
   // milliseconds reaches 1000 times the limit plus one second.
   always_comb begin
      limit_s  = {1'b0, max_age_s} + 17'd1;
      limit_ms = {limit_s, 10'd0} - {6'd0, limit_s, 4'd0} - {7'd0, limit_s, 3'd0};
      over_in  = (age_ms >= {{(MsW-27){1'b0}}, limit_ms});
      done_in  = start;
   end

   always_ff @(posedge clock) begin
      over_ff <= over_in;
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign over = over_ff;

endmodule

/* tb/frt_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker test channels
// Holds the drain length; the channel interfaces come from the block's own source.
// ----------------------------------------------------------------------------
package frt_tb_pkg;
   import frt_pkg::*;
   localparam int DrainCycles = 900;
endpackage

/* tb/fragment_reassembly_tracker_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker testbench
// Drives fragments and millisecond ticks with random idling on both channels,
// predicts every response from a model of the slot table kept in a scoreboard
// class, and writes the registers between phases while the block is idle.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_top_test;
   import frt_pkg::*;

   class reassembly_scoreboard;
      logic [15:0]    max_age;
      logic [15:0]    interval;
      logic           enabled;
      logic           valid_q [PoolSlots];
      logic [63:0]    hi_q [PoolSlots];
      logic [63:0]    lo_q [PoolSlots];
      logic [31:0]    seq_q [PoolSlots];
      logic [5:0]     total_q [PoolSlots];
      logic [31:0]    map_q [PoolSlots];
      logic [5:0]     got_q [PoolSlots];
      logic [MsW-1:0] birth_q [PoolSlots];
      logic [MsW-1:0] now_ms;
      logic [15:0]    icount;
      rsp_type        pending [$];
      int             mismatches;

      function new();
         max_age = 16'd20;
         interval = 16'd1000;
         enabled = 1'b0;
         now_ms = '0;
         icount = '0;
         mismatches = 0;
         foreach (valid_q[i]) valid_q[i] = 1'b0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] v);
         if (idx == REG_MAX_AGE) max_age = v;
         else if (idx == REG_INTERVAL) interval = v;
         else if (idx == REG_ENABLE) enabled = v[0];
      endfunction

      function int occupied();
         int n;
         n = 0;
         foreach (valid_q[i]) if (valid_q[i]) n++;
         return n;
      endfunction

      function void note_request(req_type r);
         rsp_type o;
         int found, free_s, freed;
         logic [MsW-1:0] age;
         o = '0;
         found = -1;
         free_s = -1;
         freed = 0;
         if (r.func) begin
            now_ms = now_ms + 48'd1;
            if (enabled) begin
               icount = icount + 16'd1;
               if (icount >= interval) begin
                  icount = '0;
                  for (int i = 0; i < PoolSlots; i++)
                     if (valid_q[i]) begin
                        age = (now_ms - birth_q[i]) / 1000;
                        if (age > max_age) begin
                           valid_q[i] = 1'b0;
                           freed++;
                        end
                     end
               end
            end else begin
               icount = '0;
            end
            o.status = ST_TICK;
            o.pruned_count = 5'((freed > 31) ? 31 : freed);
         end else if (r.part_count == 0 || r.part_count > MaxParts
                      || r.part_index >= r.part_count) begin
            o.status = ST_BAD;
         end else begin
            for (int i = 0; i < PoolSlots; i++)
               if (valid_q[i]) begin
                  if (found < 0 && hi_q[i] == r.sender_hi && lo_q[i] == r.sender_lo
                      && seq_q[i] == r.sequence_req) found = i;
               end else if (free_s < 0) begin
                  free_s = i;
               end
            if (found >= 0) begin
               o.slot = 4'(found);
               if (total_q[found] != r.part_count) o.status = ST_BAD;
               else if (map_q[found][r.part_index]) o.status = ST_DUPLICATE;
               else begin
                  map_q[found][r.part_index] = 1'b1;
                  got_q[found] = got_q[found] + 6'd1;
                  if (got_q[found] == r.part_count) begin
                     valid_q[found] = 1'b0;
                     o.status = ST_COMPLETE;
                  end else begin
                     o.status = ST_STORED;
                  end
               end
            end else if (free_s < 0) begin
               o.status = ST_FULL;
            end else if (r.part_count == 1) begin
               o.status = ST_COMPLETE;
               o.slot = 4'(free_s);
            end else begin
               valid_q[free_s] = 1'b1;
               hi_q[free_s] = r.sender_hi;
               lo_q[free_s] = r.sender_lo;
               seq_q[free_s] = r.sequence_req;
               total_q[free_s] = r.part_count;
               map_q[free_s] = 32'd1 << r.part_index;
               got_q[free_s] = 6'd1;
               birth_q[free_s] = now_ms;
               o.status = ST_STORED;
               o.slot = 4'(free_s);
            end
         end
         pending = {pending, o};
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response: status %0d slot %0d pruned %0d",
                        got.status, got.slot, got.pruned_count);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Response mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        want.status, want.slot, want.pruned_count,
                        got.status, got.slot, got.pruned_count);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   frt_req_if req ();
   frt_rsp_if rsp ();
   frt_csr_if csr ();

   fragment_reassembly_tracker_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   reassembly_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   // Sender identities are drawn from a small pool so that fragments collide.
   logic [63:0] pool_hi [8];
   logic [63:0] pool_lo [8];
   logic [31:0] pool_seq [8];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver side: ready idles at random; each accepted transaction is checked.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) board.check_response(rsp.data);
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   always @(posedge clock) begin
      if (quiet_cycles > 20000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Valid stays high after a transaction until the next call decides,
   // so it is never assigned twice at one edge.
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.data <= r;
      req.valid <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic write_register(logic [1:0] idx, logic [15:0] v);
      csr.data <= '{index: idx, data: v};
      csr.valid <= 1'b1;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      board.write_reg(idx, v);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (frt_tb_pkg::DrainCycles) @(posedge clock);
   endtask

   task automatic send_tick();
      req_type r;
      r = '0;
      r.func = 1'b1;
      r.sender_hi = {$urandom, $urandom};
      r.sender_lo = {$urandom, $urandom};
      r.sequence_req = $urandom;
      r.part_index = 5'($urandom);
      r.part_count = 6'($urandom);
      send_request(r);
   endtask

   task automatic send_fragment(int who, int idx, int cnt);
      req_type r;
      r.func = 1'b0;
      r.sender_hi = pool_hi[who];
      r.sender_lo = pool_lo[who];
      r.sequence_req = pool_seq[who];
      r.part_index = 5'(idx);
      r.part_count = 6'(cnt);
      send_request(r);
   endtask

   task automatic random_phase(int items);
      int who;
      int cnt;
      int roll;
      for (int n = 0; n < items; n++) begin
         roll = $urandom_range(99);
         who = $urandom_range(7);
         if (roll < 30) begin
            send_tick();
         end else if (roll < 80) begin
            // Mostly small messages so that completions are frequent.
            cnt = ($urandom_range(9) == 0) ? $urandom_range(32, 1) : $urandom_range(4, 1);
            if (board.occupied() > 12 && $urandom_range(3) != 0) begin
               for (int i = 0; i < 8; i++)
                  send_fragment(who, i % 4, 4);
            end else begin
               send_fragment(who, $urandom_range(cnt - 1), cnt);
            end
         end else if (roll < 90) begin
            pool_hi[who] = {$urandom, $urandom};
            pool_lo[who] = {$urandom, $urandom};
            pool_seq[who] = $urandom;
            send_fragment(who, $urandom_range(3), 4);
         end else begin
            send_fragment(who, $urandom_range(31), $urandom_range(63));
         end
      end
   endtask

   initial begin
      board = new();
      send_idle_pct = 31;
      recv_idle_pct = 45;
      req.valid = 1'b0;
      req.data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      reset = 1'b1;
      for (int i = 0; i < 8; i++) begin
         pool_hi[i] = {$urandom, $urandom};
         pool_lo[i] = {$urandom, $urandom};
         pool_seq[i] = $urandom;
      end
      pool_hi[0] = '1;
      pool_lo[0] = '1;
      pool_seq[0] = '1;
      pool_hi[1] = '0;
      pool_lo[1] = '0;
      pool_seq[1] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each status but full, field extremes, a full table and pruning.
      send_fragment(0, 31, 32);
      send_fragment(0, 31, 32);
      send_fragment(0, 0, 31);
      send_fragment(1, 0, 1);
      send_fragment(1, 0, 0);
      send_fragment(1, 33 % 32, 1);
      send_fragment(1, 5, 63);
      send_fragment(1, 0, 2);
      send_fragment(1, 1, 2);
      for (int i = 2; i < 8; i++) send_fragment(i, 0, 2);
      for (int i = 0; i < 9; i++) begin
         pool_seq[7] = pool_seq[7] + 1;
         send_fragment(7, 1, 3);
      end
      send_tick();
      wait_idle();

      write_register(REG_MAX_AGE, 16'd0);
      write_register(REG_INTERVAL, 16'd0);
      write_register(REG_ENABLE, 16'd1);
      repeat (1001) send_tick();
      wait_idle();
      write_register(REG_INTERVAL, 16'd1);
      write_register(REG_MAX_AGE, 16'd1);
      random_phase(25);
      wait_idle();

      write_register(REG_MAX_AGE, 16'hffff);
      write_register(REG_INTERVAL, 16'hffff);
      send_idle_pct = 45;
      recv_idle_pct = 31;
      random_phase(30);
      wait_idle();

      write_register(REG_ENABLE, 16'd0);
      write_register(REG_MAX_AGE, 16'd0);
      write_register(REG_INTERVAL, 16'd7);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(15);
      wait_idle();
      write_register(REG_ENABLE, 16'd1);
      random_phase(25);
      wait_idle();

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
